FILE: rtl/ple_pkg.sv
// Shared types for the pooled linked list engine: opcodes, result codes,
// and the command and status groups between controller and datapath.
// No dependencies.
package ple_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_EMPTY     = 2'd3
  } status_t;

  // read address source
  typedef enum logic [1:0] {
    RD_FREE = 2'd0,
    RD_HEAD = 2'd1,
    RD_LINK = 2'd2
  } rd_sel_t;

  // link write: which entry gets which link
  typedef enum logic [1:0] {
    LW_NIL_AT_FRESH = 2'd0,
    LW_FRESH_AT_CUR = 2'd1,
    LW_NEXT_AT_PREV = 2'd2,
    LW_FREE_AT_CUR  = 2'd3
  } lw_sel_t;

  typedef enum logic {
    HD_FRESH = 1'b0,
    HD_NEXT  = 1'b1
  } head_sel_t;

  typedef struct packed {
    logic      load_op;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      alloc;
    logic      lw_en;
    lw_sel_t   lw_sel;
    logic      head_wr;
    head_sel_t head_sel;
    logic      free_push;
    logic      save_next;
    logic      out_load;
    status_t   out_status;
    logic      out_elem;
    logic      out_last;
  } cmd_t;

  typedef struct packed {
    logic free_avail;
    logic head_node;
    logic link_node;
    logic prev_node;
    logic match;
    logic step_end;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/pooled_linked_list_engine.sv
// Pooled linked list engine, top level: stream ports around ple_ctrl and
// ple_datapath. Uses ple_pkg.
//
// Keeps a singly linked list of signed 32-bit values in a pool of NODE_COUNT
// nodes; unused nodes sit on a free list. Each item carries an opcode in
// in_tuser and a value in in_tdata. Insert appends at the tail (status full
// when the pool is exhausted), delete unlinks the first node holding the
// value (status not found otherwise), list streams every value from the head
// with tlast on the final one, or one "empty" result. Insert and delete give
// one result each; opcode 3 is taken and ignored. One item is worked at a
// time: in_tready is high only while the controller is idle, but a finished
// result may still be waiting in the output register. Walks go through the
// link/value memory with its registered read, one node per cycle; a list
// walk holds while a result waits in the output register. No clearing
// pass after reset: per-entry valid flops supply the initial free chain.
module pooled_linked_list_engine import ple_pkg::*; #(
  parameter int NODE_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_value (signed)
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] status, [33:2] element_value, [39:34] zero
  output logic        out_tlast
);

  localparam int OUT_USED_W = 34;
  localparam int OUT_PAD_W  = 40 - OUT_USED_W;

  cmd_t        cmd;
  sts_t        sts;
  status_t     out_status;
  logic [31:0] out_element;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .in_ready  (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ple_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .operand_value (in_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_status    (out_status),
    .out_element   (out_element),
    .out_last      (out_tlast)
  );

  // result packing, status in the low bits
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_element, out_status};

endmodule

FILE: rtl/ple_datapath.sv
// Node pool datapath: link and value memories, head pointers, walk registers
// and the result register. Driven by ple_ctrl through cmd_t; uses ple_pkg.
module ple_datapath import ple_pkg::*; #(
  parameter int NODE_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] operand_value,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_ready,
  output logic        out_valid,
  output status_t     out_status,
  output logic [31:0] out_element,
  output logic        out_last
);

  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LINK_W = $clog2(NODE_COUNT + 1);
  localparam logic [LINK_W-1:0] NIL       = LINK_W'(NODE_COUNT);
  localparam logic [ADDR_W-1:0] STEP_LAST = ADDR_W'(NODE_COUNT - 1);

  logic [LINK_W-1:0] link_mem [NODE_COUNT];
  logic [31:0]       val_mem  [NODE_COUNT];
  logic [NODE_COUNT-1:0] link_vld_r;

  logic [LINK_W-1:0] link_rd_r;
  logic              vld_rd_r;
  logic [ADDR_W-1:0] raddr_r;
  logic [31:0]       val_rd_r;

  logic [LINK_W-1:0] list_head_r, free_head_r, cur_r, prev_r, fresh_r, next_r;
  logic [ADDR_W-1:0] steps_r;
  logic [31:0]       value_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [31:0]       out_elem_r;
  logic              out_last_r;

  logic [LINK_W-1:0] link_q;
  logic [LINK_W-1:0] rd_addr;
  logic [LINK_W-1:0] lw_addr;
  logic [LINK_W-1:0] lw_data;

  // entries never written read as their initial link i+1
  assign link_q = vld_rd_r ? link_rd_r : (LINK_W'(raddr_r) + LINK_W'(1));

  always_comb begin
    case (cmd.rd_sel)
      RD_FREE: rd_addr = free_head_r;
      RD_HEAD: rd_addr = list_head_r;
      RD_LINK: rd_addr = link_q;
      default: rd_addr = list_head_r;
    endcase
  end

  always_comb begin
    case (cmd.lw_sel)
      LW_NIL_AT_FRESH: begin lw_addr = fresh_r; lw_data = NIL;         end
      LW_FRESH_AT_CUR: begin lw_addr = cur_r;   lw_data = fresh_r;     end
      LW_NEXT_AT_PREV: begin lw_addr = prev_r;  lw_data = next_r;      end
      LW_FREE_AT_CUR:  begin lw_addr = cur_r;   lw_data = free_head_r; end
      default:         begin lw_addr = cur_r;   lw_data = NIL;         end
    endcase
  end

  // memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.lw_en) begin
      link_mem[lw_addr[ADDR_W-1:0]] <= lw_data;
    end
    if (cmd.alloc) begin
      val_mem[fresh_r[ADDR_W-1:0]] <= value_r;
    end
    if (cmd.rd_en) begin
      link_rd_r <= link_mem[rd_addr[ADDR_W-1:0]];
      val_rd_r  <= val_mem[rd_addr[ADDR_W-1:0]];
      vld_rd_r  <= link_vld_r[rd_addr[ADDR_W-1:0]];
      raddr_r   <= rd_addr[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (cmd.lw_en) begin
      link_vld_r[lw_addr[ADDR_W-1:0]] <= 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_head_r <= NIL;
      free_head_r <= '0;
    end else begin
      if (cmd.head_wr) begin
        list_head_r <= (cmd.head_sel == HD_FRESH) ? fresh_r : next_r;
      end
      if (cmd.alloc) begin
        free_head_r <= link_q;
      end else if (cmd.free_push) begin
        free_head_r <= cur_r;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      value_r <= operand_value;
      fresh_r <= free_head_r;
    end
    if (cmd.rd_en) begin
      cur_r   <= rd_addr;
      prev_r  <= (cmd.rd_sel == RD_LINK) ? cur_r : NIL;
      steps_r <= (cmd.rd_sel == RD_LINK) ? steps_r + ADDR_W'(1) : '0;
    end
    if (cmd.save_next) begin
      next_r <= link_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_elem_r   <= cmd.out_elem ? val_rd_r : '0;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_elem_r;
  assign out_last    = out_last_r;

  assign sts.free_avail = (free_head_r < NIL);
  assign sts.head_node  = (list_head_r < NIL);
  assign sts.link_node  = (link_q < NIL);
  assign sts.prev_node  = (prev_r < NIL);
  assign sts.match      = (val_rd_r == value_r);
  assign sts.step_end   = (steps_r == STEP_LAST);
  assign sts.out_free   = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.lw_en && cmd.rd_en) |-> (lw_addr != rd_addr))
    else $error("link write and read hit the same entry");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && cmd.rd_sel == RD_LINK) |-> (steps_r != STEP_LAST))
    else $error("walk advanced past the pool size");

  a_heads_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (list_head_r < NIL && free_head_r < NIL) |-> (list_head_r != free_head_r))
    else $error("list and free list share a head node");
`endif

endmodule

FILE: rtl/ple_ctrl.sv
// Controller for the pooled linked list engine: sequences insert, delete
// and list walks over the datapath. Uses ple_pkg.
module ple_ctrl import ple_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_INS_ALLOC = 9'b000000010,
    ST_INS_WALK  = 9'b000000100,
    ST_DEL_WALK  = 9'b000001000,
    ST_DEL_FIX   = 9'b000010000,
    ST_DEL_FREE  = 9'b000100000,
    ST_LST_WALK  = 9'b001000000,
    ST_DONE      = 9'b010000000,
    ST_SPARE     = 9'b100000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;
  logic    walk_end;

  assign walk_end = !sts.link_node || sts.step_end;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.rd_sel = RD_HEAD;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_opcode))
            OP_INSERT: begin
              cmd.load_op = 1'b1;
              if (sts.free_avail) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_FREE;
                state_nxt  = ST_INS_ALLOC;
              end else begin
                status_nxt = STS_FULL;
                state_nxt  = ST_DONE;
              end
            end
            OP_DELETE: begin
              cmd.load_op = 1'b1;
              if (sts.head_node) begin
                cmd.rd_en = 1'b1;
                state_nxt = ST_DEL_WALK;
              end else begin
                status_nxt = STS_NOT_FOUND;
                state_nxt  = ST_DONE;
              end
            end
            OP_LIST: begin
              if (sts.head_node) begin
                cmd.rd_en = 1'b1;
                state_nxt = ST_LST_WALK;
              end else begin
                status_nxt = STS_EMPTY;
                state_nxt  = ST_DONE;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INS_ALLOC: begin
        cmd.alloc  = 1'b1;
        cmd.lw_en  = 1'b1;
        cmd.lw_sel = LW_NIL_AT_FRESH;
        if (sts.head_node) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_INS_WALK;
        end else begin
          cmd.head_wr  = 1'b1;
          cmd.head_sel = HD_FRESH;
          status_nxt   = STS_OK;
          state_nxt    = ST_DONE;
        end
      end
      ST_INS_WALK: begin
        if (walk_end) begin
          cmd.lw_en  = 1'b1;
          cmd.lw_sel = LW_FRESH_AT_CUR;
          status_nxt = STS_OK;
          state_nxt  = ST_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LINK;
        end
      end
      ST_DEL_WALK: begin
        if (sts.match) begin
          cmd.save_next = 1'b1;
          state_nxt     = ST_DEL_FIX;
        end else if (walk_end) begin
          status_nxt = STS_NOT_FOUND;
          state_nxt  = ST_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LINK;
        end
      end
      ST_DEL_FIX: begin
        if (sts.prev_node) begin
          cmd.lw_en  = 1'b1;
          cmd.lw_sel = LW_NEXT_AT_PREV;
        end else begin
          cmd.head_wr  = 1'b1;
          cmd.head_sel = HD_NEXT;
        end
        state_nxt = ST_DEL_FREE;
      end
      ST_DEL_FREE: begin
        cmd.lw_en     = 1'b1;
        cmd.lw_sel    = LW_FREE_AT_CUR;
        cmd.free_push = 1'b1;
        status_nxt    = STS_OK;
        state_nxt     = ST_DONE;
      end
      ST_LST_WALK: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = STS_OK;
          cmd.out_elem   = 1'b1;
          cmd.out_last   = walk_end;
          if (walk_end) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LINK;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = status_r;
          cmd.out_last   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      status_r <= STS_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register loaded while a result is stalled");

  a_op_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready &&
     (in_opcode == OP_INSERT || in_opcode == OP_DELETE || in_opcode == OP_LIST))
    |=> (state_r != ST_IDLE))
    else $error("accepted operation did not start");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_last) |=> (state_r == ST_IDLE))
    else $error("final result did not return the controller to idle");
`endif

endmodule
